/* rtl/fcr_pkg.sv */
// Package for the framed command receiver: parse phases, status codes,
// configuration and result structures, register indexes and reset values.
// No dependencies.
package fcr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned LEN_OUT_W  = 6;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned KEEP_BYTES = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SET_TYPE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACQ_TYPE    = 3'd5;

  localparam logic [BYTE_W-1:0] RST_HEADER_HIGH = 8'hAA;
  localparam logic [BYTE_W-1:0] RST_HEADER_LOW  = 8'h55;
  localparam logic [BYTE_W-1:0] RST_TAIL_HIGH   = 8'h55;
  localparam logic [BYTE_W-1:0] RST_TAIL_LOW    = 8'hAA;
  localparam logic [BYTE_W-1:0] RST_SET_TYPE    = 8'h01;
  localparam logic [BYTE_W-1:0] RST_ACQ_TYPE    = 8'h02;

  // payload sizes demanded by the two command types
  localparam logic [BYTE_W-1:0] SET_CFG_LEN = 8'd3;
  localparam logic [BYTE_W-1:0] ACQ_LEN     = 8'd0;

  typedef enum logic [3:0] {
    PH_HDR_H,
    PH_HDR_L,
    PH_LEN_L,
    PH_LEN_H,
    PH_TYPE,
    PH_PAYLOAD,
    PH_CHK_L,
    PH_CHK_H,
    PH_TAIL_H,
    PH_TAIL_L
  } phase_t;

  typedef enum logic [2:0] {
    ST_SET     = 3'd0,
    ST_ACQ     = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_BADLEN  = 3'd3,
    ST_TOOLONG = 3'd4,
    ST_CHECK   = 3'd5,
    ST_TAIL    = 3'd6
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_high;
    logic [BYTE_W-1:0] header_low;
    logic [BYTE_W-1:0] tail_high;
    logic [BYTE_W-1:0] tail_low;
    logic [BYTE_W-1:0] set_config_type;
    logic [BYTE_W-1:0] acquire_config_type;
  } cfg_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]   acq_depth;
    logic [BYTE_W-1:0]    scan_rate;
    logic [LEN_OUT_W-1:0] payload_length;
    logic [BYTE_W-1:0]    frame_type;
    status_t              status;
  } res_t;

endpackage

/* rtl/fcr_cfg_regs.sv */
// Configuration register file of the framed command receiver.
// Depends on fcr_pkg for register indexes, reset values and cfg_t.
module fcr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [fcr_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [fcr_pkg::BYTE_W-1:0]     wr_data,
  output fcr_pkg::cfg_t                  cfg
);

  fcr_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.header_high         <= fcr_pkg::RST_HEADER_HIGH;
      regs.header_low          <= fcr_pkg::RST_HEADER_LOW;
      regs.tail_high           <= fcr_pkg::RST_TAIL_HIGH;
      regs.tail_low            <= fcr_pkg::RST_TAIL_LOW;
      regs.set_config_type     <= fcr_pkg::RST_SET_TYPE;
      regs.acquire_config_type <= fcr_pkg::RST_ACQ_TYPE;
    end else if (wr_en) begin
      case (wr_index)
        fcr_pkg::REG_HEADER_HIGH: regs.header_high         <= wr_data;
        fcr_pkg::REG_HEADER_LOW:  regs.header_low          <= wr_data;
        fcr_pkg::REG_TAIL_HIGH:   regs.tail_high           <= wr_data;
        fcr_pkg::REG_TAIL_LOW:    regs.tail_low            <= wr_data;
        fcr_pkg::REG_SET_TYPE:    regs.set_config_type     <= wr_data;
        fcr_pkg::REG_ACQ_TYPE:    regs.acquire_config_type <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

/* rtl/fcr_parser.sv */
// Byte-wise frame parser: header hunt, length, type, payload, check, tail.
// Depends on fcr_pkg; produces at most one result per accepted byte.
module fcr_parser #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [fcr_pkg::BYTE_W-1:0] rx_byte,
  input  fcr_pkg::cfg_t              cfg,
  output logic                       res_valid,
  output fcr_pkg::res_t              res
);

  localparam int unsigned IDX_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [fcr_pkg::BYTE_W-1:0] MAX_LEN = fcr_pkg::BYTE_W'(MAX_PAYLOAD);
  localparam logic [IDX_W-1:0] KEEP_IDX = IDX_W'(fcr_pkg::KEEP_BYTES);

  fcr_pkg::phase_t phase, phase_next;
  logic [fcr_pkg::BYTE_W-1:0] frame_length, frame_length_next;
  logic [IDX_W-1:0]           payload_index, payload_index_next;
  logic [fcr_pkg::BYTE_W-1:0] running_check, running_check_next;
  logic [fcr_pkg::BYTE_W-1:0] check_low_byte, check_low_byte_next;
  logic [fcr_pkg::BYTE_W-1:0] type_byte, type_byte_next;
  logic [fcr_pkg::BYTE_W-1:0] first_payload_bytes [fcr_pkg::KEEP_BYTES];

  logic                       emit;
  logic                       restart;
  logic [IDX_W-1:0]           idx_inc;
  fcr_pkg::res_t              res_c;

  assign idx_inc = payload_index + IDX_W'(1);

  always_comb begin
    phase_next          = phase;
    frame_length_next   = frame_length;
    payload_index_next  = payload_index;
    running_check_next  = running_check;
    check_low_byte_next = check_low_byte;
    type_byte_next      = type_byte;
    emit                = 1'b0;
    restart             = 1'b0;
    res_c               = '0;
    res_c.frame_type     = type_byte;
    res_c.payload_length = frame_length[fcr_pkg::LEN_OUT_W-1:0];

    case (phase)
      fcr_pkg::PH_HDR_H: begin
        if (rx_byte == cfg.header_high) phase_next = fcr_pkg::PH_HDR_L;
      end
      fcr_pkg::PH_HDR_L: begin
        // a repeated high header byte keeps the sync
        if (rx_byte == cfg.header_low) phase_next = fcr_pkg::PH_LEN_L;
        else if (rx_byte != cfg.header_high) phase_next = fcr_pkg::PH_HDR_H;
      end
      fcr_pkg::PH_LEN_L: begin
        frame_length_next  = rx_byte;
        running_check_next = rx_byte;
        phase_next         = fcr_pkg::PH_LEN_H;
      end
      fcr_pkg::PH_LEN_H: begin
        if (rx_byte != '0 || frame_length > MAX_LEN) begin
          emit                 = 1'b1;
          restart              = 1'b1;
          res_c.status         = fcr_pkg::ST_TOOLONG;
          res_c.frame_type     = '0;
          res_c.payload_length = '0;
        end else begin
          running_check_next = running_check ^ rx_byte;
          payload_index_next = '0;
          phase_next         = fcr_pkg::PH_TYPE;
        end
      end
      fcr_pkg::PH_TYPE: begin
        type_byte_next     = rx_byte;
        running_check_next = running_check ^ rx_byte;
        phase_next = (frame_length == '0) ? fcr_pkg::PH_CHK_L : fcr_pkg::PH_PAYLOAD;
      end
      fcr_pkg::PH_PAYLOAD: begin
        payload_index_next = idx_inc;
        running_check_next = running_check ^ rx_byte;
        if (fcr_pkg::BYTE_W'(idx_inc) >= frame_length) phase_next = fcr_pkg::PH_CHK_L;
      end
      fcr_pkg::PH_CHK_L: begin
        check_low_byte_next = rx_byte;
        phase_next          = fcr_pkg::PH_CHK_H;
      end
      fcr_pkg::PH_CHK_H: begin
        if (rx_byte == '0 && check_low_byte == running_check) begin
          phase_next = fcr_pkg::PH_TAIL_H;
        end else begin
          emit         = 1'b1;
          restart      = 1'b1;
          res_c.status = fcr_pkg::ST_CHECK;
        end
      end
      fcr_pkg::PH_TAIL_H: begin
        if (rx_byte == cfg.tail_high) begin
          phase_next = fcr_pkg::PH_TAIL_L;
        end else begin
          emit         = 1'b1;
          restart      = 1'b1;
          res_c.status = fcr_pkg::ST_TAIL;
        end
      end
      fcr_pkg::PH_TAIL_L: begin
        emit    = 1'b1;
        restart = 1'b1;
        if (rx_byte != cfg.tail_low) begin
          res_c.status = fcr_pkg::ST_TAIL;
        end else if (type_byte == cfg.set_config_type) begin
          if (frame_length != fcr_pkg::SET_CFG_LEN) begin
            res_c.status = fcr_pkg::ST_BADLEN;
          end else begin
            res_c.status    = fcr_pkg::ST_SET;
            res_c.scan_rate = first_payload_bytes[0];
            res_c.acq_depth = {first_payload_bytes[2], first_payload_bytes[1]};
          end
        end else if (type_byte == cfg.acquire_config_type) begin
          res_c.status = (frame_length != fcr_pkg::ACQ_LEN) ? fcr_pkg::ST_BADLEN
                                                             : fcr_pkg::ST_ACQ;
        end else begin
          res_c.status = fcr_pkg::ST_UNKNOWN;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    if (restart) begin
      phase_next         = fcr_pkg::PH_HDR_H;
      frame_length_next  = '0;
      payload_index_next = '0;
      running_check_next = '0;
      type_byte_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= fcr_pkg::PH_HDR_H;
      frame_length   <= '0;
      payload_index  <= '0;
      running_check  <= '0;
      check_low_byte <= '0;
      type_byte      <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      frame_length   <= frame_length_next;
      payload_index  <= payload_index_next;
      running_check  <= running_check_next;
      check_low_byte <= check_low_byte_next;
      type_byte      <= type_byte_next;
    end
  end

  // keep only the leading payload bytes
  always_ff @(posedge clk) begin
    if (accept && phase == fcr_pkg::PH_PAYLOAD && payload_index < KEEP_IDX) begin
      first_payload_bytes[payload_index[1:0]] <= rx_byte;
    end
  end

  assign res_valid = accept & emit;
  assign res       = res_c;

endmodule

/* rtl/fcr_out_buf.sv */
// Result register with a skid stage so the parser keeps taking bytes while a
// result waits on the output. Depends on fcr_pkg for res_t.
module fcr_out_buf (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  fcr_pkg::res_t                      in_res,
  output logic                               in_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fcr_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int unsigned PAD_W = fcr_pkg::OUT_DATA_W - $bits(fcr_pkg::res_t);

  logic          out_full;
  fcr_pkg::res_t out_res;
  logic          skid_full;
  fcr_pkg::res_t skid_res;
  logic          take;

  assign in_ready = ~skid_full;
  assign take     = in_valid & ~skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_full || out_ready) begin
      // output register free this cycle: drain the skid stage first
      if (skid_full) begin
        out_full  <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_full <= take;
      end
    end else if (take) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || out_ready) begin
      out_res <= skid_full ? skid_res : in_res;
    end else if (take) begin
      skid_res <= in_res;
    end
  end

  assign out_valid = out_full;
  assign out_data  = {{PAD_W{1'b0}}, out_res};

endmodule

/* rtl/framed_command_receiver_unit.sv */
// Framed command receiver. Takes one received byte per beat on s_* and parses
// frames: header_high, header_low, 16-bit little-endian length, type, payload,
// 16-bit little-endian XOR check, tail_high, tail_low. One status beat leaves
// on m_* when a frame ends or is aborted; header hunting gives none. A byte is
// taken every clock while s_tready is high; parse state updates per accepted
// byte and its result is registered in the output or skid stage. A skid
// stage behind the output register lets the input keep flowing for one more
// result while m_tready is low, so throughput is one byte per clock whenever
// the output side takes results as they come. There is no clearing pass after
// reset. Write configuration only while the block is idle.
// Depends on fcr_pkg, fcr_cfg_regs, fcr_parser and fcr_out_buf.
module framed_command_receiver_unit #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] rx_byte
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [2:0] status, [10:3] frame_type, [16:11] payload_length,
  // [24:17] scan_rate, [40:25] acq_depth, [47:41] zero
  output logic [fcr_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fcr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcr_pkg::BYTE_W-1:0]         cfg_data
);

  fcr_pkg::cfg_t cfg;
  fcr_pkg::res_t res;
  logic          res_valid;
  logic          accept;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid & s_tready;

  fcr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fcr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (s_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  fcr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
